@@ rtl/core/qau_pkg.sv @@
// Package for the quaternion arithmetic unit: operation and status codes,
// fixed datapath widths and the default fraction width. No dependencies.
package qau_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Sum of four squared 32-bit values, and Hamilton sums, fit in 66 bits.
    localparam int SUM_W    = 66;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;
    localparam int QUOT_W   = 32;

    typedef enum logic [3:0] {
        KIND_ADD       = 4'd0,
        KIND_SUB       = 4'd1,
        KIND_MUL       = 4'd2,
        KIND_SCALE     = 4'd3,
        KIND_CONJ      = 4'd4,
        KIND_PURE      = 4'd5,
        KIND_INV       = 4'd6,
        KIND_NORMALIZE = 4'd7,
        KIND_NORM      = 4'd8,
        KIND_NORM_SQ   = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

endpackage

@@ rtl/core/qau_sqrt_step.sv @@
// One digit step of the integer square root: takes two radicand bits and
// produces one root bit. Depends on qau_pkg.
module qau_sqrt_step
    import qau_pkg::*;
(
    input  logic [SQ_REM_W-1:0] rem_in,
    input  logic [ROOT_W-1:0]   root_in,
    input  logic [1:0]          pair,
    output logic [SQ_REM_W-1:0] rem_out,
    output logic [ROOT_W-1:0]   root_out
);

    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;

    assign rem_sh = {rem_in[SQ_REM_W-3:0], pair};
    assign trial  = {1'b0, root_in, 2'b01};

    always_comb
    begin
        if (rem_sh >= trial)
        begin
            rem_out  = rem_sh - trial;
            root_out = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out  = rem_sh;
            root_out = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

endmodule

@@ rtl/core/qau_div_step.sv @@
// One bit step of restoring division: shifts in one numerator bit and
// subtracts the divisor where it fits. Depends on qau_pkg.
module qau_div_step
    import qau_pkg::*;
(
    input  logic [SUM_W-1:0] rem_in,
    input  logic             bit_in,
    input  logic [SUM_W-1:0] den,
    output logic [SUM_W-1:0] rem_out,
    output logic             q_bit
);

    logic [SUM_W:0] rem_sh;
    logic [SUM_W:0] diff;

    assign rem_sh  = {rem_in, bit_in};
    assign diff    = rem_sh - {1'b0, den};
    assign q_bit   = (rem_sh >= {1'b0, den});
    assign rem_out = q_bit ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];

endmodule

@@ rtl/core/quaternion_arithmetic_unit.sv @@
// Quaternion arithmetic unit top level: pipeline of multiply, sum, rounding,
// square root and division stages. Depends on qau_pkg, qau_sqrt_step, qau_div_step.

// The unit takes one quaternion pair per clock and delivers one result per
// clock when the output side does not stall. Every operation goes through the
// same pipeline, whose depth comes from the 33-step square root and the
// 32-step divider, one digit per stage. An output register with a one-entry
// skid buffer absorbs a stall, after which the input stalls until the skid
// entry drains.
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [3:0]         kind,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scale_factor,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] r_w,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic [30:0]        norm_value,
    output logic [1:0]         status
);

    localparam int NUM_W = 32 + 2 * FRAC_BITS;
    localparam int NP    = 4 + ROOT_W + 1 + QUOT_W;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        kind_t            kind;
        logic [3:0][31:0] r;
        logic [30:0]      normv;
        logic             sat;
        logic [SUM_W-1:0] s;
        logic [3:0][31:0] mag;
        logic [3:0]       neg;
    } base_t;

    typedef struct packed {
        base_t               base;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        base_t                  base;
        logic [SUM_W-1:0]       den;
        logic [3:0][31:0]       num;
        logic [3:0][SUM_W-1:0]  rem;
        logic [3:0][QUOT_W-1:0] q;
        logic [3:0]             ovf;
    } dv_t;

    typedef struct packed {
        logic [3:0][31:0] r;
        logic [30:0]      normv;
        status_t          status;
    } res_t;

    function automatic logic [32:0] clamp_s33(input logic signed [32:0] t);
        if (t[32] == t[31])
            return {1'b0, t[31:0]};
        else
            return {1'b1, t[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    function automatic logic [32:0] clamp_s66(input logic signed [SUM_W-1:0] t);
        if ((&t[SUM_W-1:31]) || !(|t[SUM_W-1:31]))
            return {1'b0, t[31:0]};
        else
            return {1'b1, t[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_p(input logic signed [63:0] p);
        return SUM_W'(p);
    endfunction

    // Pipeline control: every stage advances together unless the skid holds.
    logic          en;
    logic [NP-1:0] v_reg;
    logic          out_v_reg;
    logic          skid_v_reg;
    res_t          out_reg;
    res_t          skid_reg;
    res_t          fin;

    assign en         = !skid_v_reg;
    assign item_stall = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NP-2:0], item_valid};
    end

    // Stage 0: input registers.
    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];
    kind_t              s0_kind_reg;
    logic signed [31:0] s0_a_reg [4];
    logic signed [31:0] s0_b_reg [4];
    logic signed [31:0] s0_sf_reg;

    assign a_in[0] = a_w;
    assign a_in[1] = a_x;
    assign a_in[2] = a_y;
    assign a_in[3] = a_z;
    assign b_in[0] = b_w;
    assign b_in[1] = b_x;
    assign b_in[2] = b_y;
    assign b_in[3] = b_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_kind_reg <= kind_t'(kind);
            s0_sf_reg   <= scale_factor;
            for (int i = 0; i < 4; i++)
            begin
                s0_a_reg[i] <= a_in[i];
                s0_b_reg[i] <= b_in[i];
            end
        end
    end

    // Stage 1: sixteen products, plus the operations that need no multiply.
    // Outside the Hamilton product the diagonal holds squares and the
    // neighbor column holds the scaled components.
    logic signed [63:0] s1_prod_next [4][4];
    logic [3:0][31:0]   s1_simp_next;
    logic               s1_simp_sat_next;
    logic [3:0][31:0]   s1_mag_next;
    logic [3:0]         s1_neg_next;
    logic signed [63:0] s1_prod_reg [4][4];
    kind_t              s1_kind_reg;
    logic [3:0][31:0]   s1_simp_reg;
    logic               s1_simp_sat_reg;
    logic [3:0][31:0]   s1_mag_reg;
    logic [3:0]         s1_neg_reg;

    always_comb
    begin
        logic signed [31:0] op_b;
        logic signed [32:0] t;
        logic [32:0]        c;
        s1_simp_sat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (s0_kind_reg == KIND_MUL)
                    op_b = s0_b_reg[j];
                else if (i == j)
                    op_b = s0_a_reg[i];
                else
                    op_b = s0_sf_reg;
                s1_prod_next[i][j] = s0_a_reg[i] * op_b;
            end
            case (s0_kind_reg)
                KIND_ADD:  t = 33'(s0_a_reg[i]) + 33'(s0_b_reg[i]);
                KIND_SUB:  t = 33'(s0_a_reg[i]) - 33'(s0_b_reg[i]);
                KIND_CONJ: t = (i == 0) ? 33'(s0_a_reg[i]) : -33'(s0_a_reg[i]);
                KIND_PURE: t = (i == 0) ? '0 : 33'(s0_a_reg[i]);
                default:   t = '0;
            endcase
            c                = clamp_s33(t);
            s1_simp_next[i]  = c[31:0];
            s1_simp_sat_next = s1_simp_sat_next | c[32];
            s1_mag_next[i]   = s0_a_reg[i][31] ? (~s0_a_reg[i] + 32'd1) : s0_a_reg[i];
            case (s0_kind_reg)
                KIND_INV:
                    s1_neg_next[i] = (i == 0) ? s0_a_reg[i][31]
                                              : (!s0_a_reg[i][31] && (s0_a_reg[i] != 0));
                KIND_NORMALIZE: s1_neg_next[i] = s0_a_reg[i][31];
                default:        s1_neg_next[i] = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg     <= s1_prod_next;
            s1_kind_reg     <= s0_kind_reg;
            s1_simp_reg     <= s1_simp_next;
            s1_simp_sat_reg <= s1_simp_sat_next;
            s1_mag_reg      <= s1_mag_next;
            s1_neg_reg      <= s1_neg_next;
        end
    end

    // Stage 2: exact sums at double fraction width.
    logic signed [SUM_W-1:0] s2_acc_next [4];
    logic [SUM_W-1:0]        s2_s_next;
    logic signed [SUM_W-1:0] s2_acc_reg [4];
    logic [SUM_W-1:0]        s2_s_reg;
    kind_t                   s2_kind_reg;
    logic [3:0][31:0]        s2_simp_reg;
    logic                    s2_simp_sat_reg;
    logic [3:0][31:0]        s2_mag_reg;
    logic [3:0]              s2_neg_reg;

    always_comb
    begin
        if (s1_kind_reg == KIND_MUL)
        begin
            s2_acc_next[0] = ext_p(s1_prod_reg[0][0]) - ext_p(s1_prod_reg[1][1])
                           - ext_p(s1_prod_reg[2][2]) - ext_p(s1_prod_reg[3][3]);
            s2_acc_next[1] = ext_p(s1_prod_reg[0][1]) + ext_p(s1_prod_reg[1][0])
                           + ext_p(s1_prod_reg[2][3]) - ext_p(s1_prod_reg[3][2]);
            s2_acc_next[2] = ext_p(s1_prod_reg[0][2]) + ext_p(s1_prod_reg[2][0])
                           + ext_p(s1_prod_reg[3][1]) - ext_p(s1_prod_reg[1][3]);
            s2_acc_next[3] = ext_p(s1_prod_reg[0][3]) + ext_p(s1_prod_reg[3][0])
                           + ext_p(s1_prod_reg[1][2]) - ext_p(s1_prod_reg[2][1]);
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                s2_acc_next[i] = ext_p(s1_prod_reg[i][(i + 1) % 4]);
        end
        s2_s_next = SUM_W'($unsigned(s1_prod_reg[0][0])) + SUM_W'($unsigned(s1_prod_reg[1][1]))
                  + SUM_W'($unsigned(s1_prod_reg[2][2])) + SUM_W'($unsigned(s1_prod_reg[3][3]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_acc_reg      <= s2_acc_next;
            s2_s_reg        <= s2_s_next;
            s2_kind_reg     <= s1_kind_reg;
            s2_simp_reg     <= s1_simp_reg;
            s2_simp_sat_reg <= s1_simp_sat_reg;
            s2_mag_reg      <= s1_mag_reg;
            s2_neg_reg      <= s1_neg_reg;
        end
    end

    // Stage 3: round half up, saturate, and pick the result by operation.
    base_t s3_next;
    base_t s3_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] rnd;
        logic [SUM_W-1:0]        sq;
        logic [32:0]             c;
        s3_next.kind  = s2_kind_reg;
        s3_next.r     = '0;
        s3_next.normv = '0;
        s3_next.sat   = 1'b0;
        s3_next.s     = s2_s_reg;
        s3_next.mag   = s2_mag_reg;
        s3_next.neg   = s2_neg_reg;
        sq = (s2_s_reg + HALF) >> FRAC_BITS;
        for (int i = 0; i < 4; i++)
        begin
            rnd = (s2_acc_reg[i] + $signed(HALF)) >>> FRAC_BITS;
            c   = clamp_s66(rnd);
            case (s2_kind_reg)
                KIND_MUL, KIND_SCALE:
                begin
                    s3_next.r[i] = c[31:0];
                    s3_next.sat  = s3_next.sat | c[32];
                end
                KIND_ADD, KIND_SUB, KIND_CONJ, KIND_PURE:
                begin
                    s3_next.r[i] = s2_simp_reg[i];
                    s3_next.sat  = s2_simp_sat_reg;
                end
                default: s3_next.r[i] = '0;
            endcase
        end
        if (s2_kind_reg == KIND_NORM_SQ)
        begin
            if (|sq[SUM_W-1:31])
            begin
                s3_next.sat   = 1'b1;
                s3_next.normv = '1;
            end
            else
                s3_next.normv = sq[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_reg <= s3_next;
    end

    // Square root of the squared norm, one root bit per stage.
    sq_t sq_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sq
        sq_t                 sq_prev;
        logic [SQ_REM_W-1:0] rem_n;
        logic [ROOT_W-1:0]   root_n;

        if (k == 0)
        begin : g_first
            assign sq_prev = {s3_reg, {SQ_REM_W{1'b0}}, {ROOT_W{1'b0}}};
        end
        else
        begin : g_next
            assign sq_prev = sq_reg[k-1];
        end

        qau_sqrt_step u_sqrt_step (
            .rem_in   (sq_prev.rem),
            .root_in  (sq_prev.root),
            .pair     (sq_prev.base.s[2*(ROOT_W-1-k)+1 -: 2]),
            .rem_out  (rem_n),
            .root_out (root_n)
        );

        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[k] <= {sq_prev.base, rem_n, root_n};
        end
    end

    // Divider setup: the inverse divides by the squared norm, normalize by
    // the norm. An inverse quotient of 2^32 or more only needs to saturate.
    dv_t dset_next;
    dv_t dset_reg;

    always_comb
    begin
        logic [ROOT_W-1:0] m;
        logic [NUM_W-1:0]  num_full;
        logic [SUM_W-1:0]  hi;
        m              = sq_reg[ROOT_W-1].root;
        dset_next.base = sq_reg[ROOT_W-1].base;
        if (dset_next.base.kind == KIND_NORM)
        begin
            dset_next.base.normv = m[30:0];
            if (m[ROOT_W-1] || m[31])
            begin
                dset_next.base.sat   = 1'b1;
                dset_next.base.normv = '1;
            end
        end
        dset_next.den = (dset_next.base.kind == KIND_INV) ? dset_next.base.s : SUM_W'(m);
        dset_next.q   = '0;
        for (int l = 0; l < 4; l++)
        begin
            if (dset_next.base.kind == KIND_INV)
                num_full = NUM_W'(dset_next.base.mag[l]) << (2 * FRAC_BITS);
            else
                num_full = NUM_W'(dset_next.base.mag[l]) << FRAC_BITS;
            hi                = SUM_W'(num_full[NUM_W-1:32]);
            dset_next.rem[l]  = hi;
            dset_next.ovf[l]  = (hi >= dset_next.den);
            dset_next.num[l]  = num_full[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dset_reg <= dset_next;
    end

    // Four divider lanes, one quotient bit per stage.
    dv_t dv_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_dv
        dv_t                   dv_prev;
        dv_t                   dv_new;
        logic [3:0][SUM_W-1:0] rem_n;
        logic [3:0]            qb;

        if (k == 0)
        begin : g_first
            assign dv_prev = dset_reg;
        end
        else
        begin : g_next
            assign dv_prev = dv_reg[k-1];
        end

        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            qau_div_step u_div_step (
                .rem_in  (dv_prev.rem[l]),
                .bit_in  (dv_prev.num[l][QUOT_W-1-k]),
                .den     (dv_prev.den),
                .rem_out (rem_n[l]),
                .q_bit   (qb[l])
            );
        end

        always_comb
        begin
            dv_new     = dv_prev;
            dv_new.rem = rem_n;
            for (int l = 0; l < 4; l++)
                dv_new.q[l] = {dv_prev.q[l][QUOT_W-2:0], qb[l]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k] <= dv_new;
        end
    end

    // Final signs, inverse saturation and the zero-quaternion case.
    always_comb
    begin
        dv_t         last;
        logic        sat;
        logic        dz;
        logic [31:0] lim;
        last      = dv_reg[QUOT_W-1];
        fin.r     = last.base.r;
        fin.normv = last.base.normv;
        sat       = last.base.sat;
        dz        = (last.base.s == '0)
                 && ((last.base.kind == KIND_INV) || (last.base.kind == KIND_NORMALIZE));
        for (int l = 0; l < 4; l++)
        begin
            lim = last.base.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (last.base.kind == KIND_INV)
            begin
                if (last.ovf[l] || (last.q[l] > lim))
                begin
                    sat      = 1'b1;
                    fin.r[l] = lim;
                end
                else
                    fin.r[l] = last.base.neg[l] ? (~last.q[l] + 32'd1) : last.q[l];
            end
            else if (last.base.kind == KIND_NORMALIZE)
                fin.r[l] = last.base.neg[l] ? (~last.q[l] + 32'd1) : last.q[l];
        end
        if (dz)
        begin
            fin.r      = '0;
            fin.normv  = '0;
            fin.status = STATUS_DIV_ZERO;
        end
        else if (sat)
            fin.status = STATUS_SAT;
        else
            fin.status = STATUS_OK;
    end

    // Output register and skid entry.
    logic take;
    logic out_free;
    logic prod_v;

    assign take     = out_v_reg && !result_stall;
    assign out_free = !out_v_reg || take;
    assign prod_v   = en && v_reg[NP-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (prod_v)
        begin
            if (out_free)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (out_free)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg && out_free)
            out_reg <= skid_reg;
        else if (!skid_v_reg && prod_v && out_free)
            out_reg <= fin;
        if (!skid_v_reg && prod_v && !out_free)
            skid_reg <= fin;
    end

    assign result_valid = out_v_reg;
    assign r_w          = out_reg.r[0];
    assign r_x          = out_reg.r[1];
    assign r_y          = out_reg.r[2];
    assign r_z          = out_reg.r[3];
    assign norm_value   = out_reg.normv;
    assign status       = out_reg.status;

endmodule
